FILE: hw/rtl/prqs_pkg.sv
`timescale 1ns / 1ps

package prqs_pkg;

   localparam int ID_W       = 4;
   localparam int PRIO_W     = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef enum logic {
      OP_ENQUEUE  = 1'b0,
      OP_SCHEDULE = 1'b1
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic select;
      logic update;
   } prqs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } prqs_status_type;

endpackage

FILE: hw/rtl/prqs_ctrl.sv
`timescale 1ns / 1ps

module prqs_ctrl
   import prqs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  prqs_status_type status,
   output prqs_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      tready_ff, tready_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && tready_ff) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register can take the result
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      tready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tready_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tready_ff <= tready_in;
      end
   end

   assign req_tready = tready_ff;
   assign cmd.latch  = req_tvalid && tready_ff;
   assign cmd.select = (state_ff == ST_SELECT);
   assign cmd.update = (state_ff == ST_UPDATE) && status.out_free;

`ifndef SYNTHESIS
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch, cmd.select, cmd.update}))
      else $error("controller issued overlapping commands");
`endif

endmodule

FILE: hw/rtl/prqs_datapath.sv
`timescale 1ns / 1ps

module prqs_datapath
   import prqs_pkg::*;
#(
   parameter int TASKS  = 16,
   parameter int LEVELS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  prqs_cmd_type          cmd,
   output prqs_status_type       status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int TASK_W = $clog2(TASKS);

   // latched word
   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [PRIO_W-1:0]   pr_ff;

   logic [LEVELS-1:0]   bitmap_ff, bitmap_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                hit_ff, hit_in;

   logic [ID_W-1:0]     head_mem [LEVELS];
   logic [ID_W-1:0]     tail_mem [LEVELS];
   logic [ID_W-1:0]     link_mem [TASKS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                granted_ff, granted_in;
   logic [ID_W-1:0]     otask_ff, otask_in;
   logic [PRIO_W-1:0]   oprio_ff, oprio_in;

   logic [LVL_W-1:0]    first_lvl;
   logic                id_ok, pr_ok;
   logic [ID_W-1:0]     head_rd, tail_rd, link_rd;
   logic                level_busy, last_entry, is_sched;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= op_type'(req_tuser);
         id_ff <= req_tdata[ID_W-1:0];
         pr_ff <= req_tdata[ID_W+PRIO_W-1:ID_W];
      end
   end

   // select step: lowest non-empty level, or the enqueue level
   always_comb begin
      first_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (bitmap_ff[i]) first_lvl = LVL_W'(i);
      end
      id_ok = int'(id_ff) < TASKS;
      pr_ok = int'(pr_ff) < LEVELS;
      if (op_ff == OP_SCHEDULE) begin
         lvl_in = first_lvl;
         hit_in = |bitmap_ff;
      end else begin
         lvl_in = LVL_W'(pr_ff);
         hit_in = id_ok && pr_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         lvl_ff <= lvl_in;
         hit_ff <= hit_in;
      end
   end

   // update step
   assign is_sched   = (op_ff == OP_SCHEDULE);
   assign head_rd    = head_mem[lvl_ff];
   assign tail_rd    = tail_mem[lvl_ff];
   assign link_rd    = link_mem[TASK_W'(head_rd)];
   assign level_busy = bitmap_ff[lvl_ff];
   assign last_entry = (head_rd == tail_rd);

   always_comb begin
      bitmap_in = bitmap_ff;
      if (cmd.update && hit_ff) begin
         if (!is_sched) bitmap_in[lvl_ff] = 1'b1;
         else if (last_entry) bitmap_in[lvl_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && hit_ff) begin
         if (!is_sched) begin
            if (level_busy) link_mem[TASK_W'(tail_rd)] <= id_ff;
            else            head_mem[lvl_ff] <= id_ff;
            tail_mem[lvl_ff] <= id_ff;
         end else if (!last_entry) begin
            head_mem[lvl_ff] <= link_rd;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      granted_in   = granted_ff;
      otask_in     = otask_ff;
      oprio_in     = oprio_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         granted_in   = is_sched && hit_ff;
         otask_in     = (is_sched && hit_ff) ? head_rd : '0;
         oprio_in     = (is_sched && hit_ff) ? PRIO_W'(lvl_ff) : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bitmap_ff    <= bitmap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      granted_ff <= granted_in;
      otask_ff   <= otask_in;
      oprio_ff   <= oprio_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = granted_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ID_W - PRIO_W){1'b0}}, oprio_ff, otask_ff};

`ifndef SYNTHESIS
   a_sched_level_set: assert property (@(posedge clock) disable iff (reset)
      cmd.update && is_sched && hit_ff |-> bitmap_ff[lvl_ff])
      else $error("schedule popped from an empty level");

   a_enq_no_grant: assert property (@(posedge clock) disable iff (reset)
      cmd.update && !is_sched |=> rsp_valid_ff && !granted_ff)
      else $error("enqueue produced a grant");

   a_sched_map_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.update && is_sched |=> $countones(bitmap_ff) <= $countones($past(bitmap_ff)))
      else $error("schedule set a ready bit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !cmd.update)
      else $error("pending result overwritten");
`endif

endmodule

FILE: hw/rtl/priority_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// Priority ready queue: one FIFO of task numbers per priority level.
// Input channel req_*: one word per operation. req_tuser selects the
// operation (0 enqueue task_id at task_priority, 1 schedule the most urgent
// ready task). Result channel rsp_*: exactly one word per input word, in
// order. rsp_tuser is the grant flag; task and level are zero unless granted.
// Enqueues with an out-of-range task or level change nothing.
// Timing: a word is accepted; in the next cycle the level is picked (priority
// encoder over the ready bitmap for a schedule, task_priority for an enqueue);
// the lists are then updated, once the output register is free, and the result
// is valid on the following cycle. The next word is accepted only after the
// update step, as set by the accept/select/update sequence of the controller.
// The result sits in an output register, so the next word is accepted while
// it waits. If the receiver stalls, the following word is held in its update
// step until the register frees.
// Reset empties every level (bitmap cleared) and holds req_tready low; list
// storage is not cleared and takes no clearing pass.
module priority_ready_queue_scheduler_unit
   import prqs_pkg::*;
#(
   parameter int TASKS  = 16,
   parameter int LEVELS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // task_id[3:0], task_priority[8:4]
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_task[3:0], out_priority[8:4]
   output logic                  rsp_tuser   // granted
);

   prqs_cmd_type    cmd;
   prqs_status_type status;

   prqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prqs_datapath #(
      .TASKS  (TASKS),
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import prqs_pkg::*;

   localparam int NUM_TASKS  = 16;
   localparam int NUM_LEVELS = 32;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } sched_req_type;

   typedef struct packed {
      logic              granted;
      logic [ID_W-1:0]   task_num;
      logic [PRIO_W-1:0] prio;
   } sched_rsp_type;

   typedef struct {
      logic [NUM_LEVELS-1:0] bitmap;
      logic [ID_W-1:0]       head[NUM_LEVELS];
      logic [ID_W-1:0]       tail[NUM_LEVELS];
      logic [ID_W-1:0]       link[NUM_TASKS];
      bit                    link_set[NUM_TASKS];
   } queue_state_type;

   typedef enum int {
      PH_STEADY,
      PH_SENDER_GAPS,
      PH_SINK_STALLS,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } traffic_phase_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // task_id[3:0], task_priority[8:4]
   logic                  req_tuser  = 1'b0; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_task[3:0], out_priority[8:4]
   logic                  rsp_tuser;        // granted

   priority_ready_queue_scheduler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sched_req_type     pending_words[$];
   sched_rsp_type     expected_picks[$];
   queue_state_type   plan_state;   // tracks the stimulus as it is generated
   queue_state_type   live_state;   // advanced on each accepted word
   bit                queued[NUM_TASKS];
   traffic_phase_type phase      = PH_STEADY;
   bit                req_taken  = 1'b0;
   int                hold_left  = 300;
   int                error_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic queue_state_type empty_queues();
      queue_state_type s;
      s.bitmap = '0;
      foreach (s.head[i]) begin
         s.head[i] = '0;
         s.tail[i] = '0;
      end
      foreach (s.link[i]) begin
         s.link[i]     = '0;
         s.link_set[i] = 1'b0;
      end
      return s;
   endfunction

   function automatic int lowest_ready(logic [NUM_LEVELS-1:0] map);
      for (int i = 0; i < NUM_LEVELS; i++)
         if (map[i])
            return i;
      return -1;
   endfunction

   // ids and levels span their full widths here, so no word is out of range
   function automatic sched_rsp_type ready_queue_step(inout queue_state_type s,
                                                      input sched_req_type w);
      sched_rsp_type     r;
      int                lvl;
      logic [PRIO_W-1:0] lv;
      logic [ID_W-1:0]   h;
      r = '0;
      if (w.op == OP_ENQUEUE) begin
         if (s.bitmap[w.prio]) begin
            s.link[s.tail[w.prio]]     = w.id;
            s.link_set[s.tail[w.prio]] = 1'b1;
         end else begin
            s.head[w.prio]   = w.id;
            s.bitmap[w.prio] = 1'b1;
         end
         s.tail[w.prio] = w.id;
      end else begin
         lvl = lowest_ready(s.bitmap);
         if (lvl >= 0) begin
            lv = lvl[PRIO_W-1:0];
            h  = s.head[lv];
            if (h == s.tail[lv])
               s.bitmap[lv] = 1'b0;
            else
               s.head[lv] = s.link[h];
            r.granted  = 1'b1;
            r.task_num = h;
            r.prio     = lv;
         end
      end
      return r;
   endfunction

   // True when popping everything never follows a link that was never written.
   function automatic bit drains_cleanly(queue_state_type s);
      sched_req_type     pop;
      int                lvl;
      logic [PRIO_W-1:0] lv;
      pop = '{op: OP_SCHEDULE, id: '0, prio: '0};
      for (int n = 0; n < 256; n++) begin
         lvl = lowest_ready(s.bitmap);
         if (lvl < 0)
            return 1'b1;
         lv = lvl[PRIO_W-1:0];
         if (s.head[lv] != s.tail[lv] && !s.link_set[s.head[lv]])
            return 1'b0;
         void'(ready_queue_step(s, pop));
      end
      return 1'b0;
   endfunction

   function automatic bit add_word(sched_req_type w);
      queue_state_type trial;
      sched_rsp_type   r;
      trial = plan_state;
      r = ready_queue_step(trial, w);
      if (w.op == OP_ENQUEUE) begin
         if (!drains_cleanly(trial))
            return 1'b0;
         queued[w.id] = 1'b1;
      end else if (r.granted) begin
         queued[r.task_num] = 1'b0;
      end
      plan_state = trial;
      pending_words.push_back(w);
      return 1'b1;
   endfunction

   function automatic sched_req_type mk(op_type op, int id, int prio);
      sched_req_type w;
      w.op   = op;
      w.id   = id[ID_W-1:0];
      w.prio = prio[PRIO_W-1:0];
      return w;
   endfunction

   function automatic int sender_gap_pct(traffic_phase_type p);
      case (p)
         PH_SENDER_GAPS: return 45;
         PH_BOTH_IDLE:   return 31;
         default:        return 0;
      endcase
   endfunction

   function automatic int sink_stall_pct(traffic_phase_type p);
      case (p)
         PH_SINK_STALLS: return 45;
         PH_BOTH_IDLE:   return 31;
         default:        return 0;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      sched_req_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= sender_gap_pct(phase)) begin
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'({w.prio, w.id});
            req_tuser  <= w.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver; one long hold-off at the start of the backpressure phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (phase == PH_BACKPRESSURE && hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct(phase));
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_req_type w;
      sched_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            w.op   = op_type'(req_tuser);
            w.id   = req_tdata[ID_W-1:0];
            w.prio = req_tdata[ID_W +: PRIO_W];
            expected_picks.push_back(ready_queue_step(live_state, w));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_picks.size() == 0) begin
               $error("result word with nothing expected: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_tuser !== want.granted) begin
                  $error("granted mismatch: expected %0d, got %0d", want.granted, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[ID_W-1:0] !== want.task_num) begin
                  $error("out_task mismatch: expected %0d, got %0d",
                         want.task_num, rsp_tdata[ID_W-1:0]);
                  error_count++;
               end
               if (rsp_tdata[ID_W +: PRIO_W] !== want.prio) begin
                  $error("out_priority mismatch: expected %0d, got %0d",
                         want.prio, rsp_tdata[ID_W +: PRIO_W]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      sched_req_type w;
      int            n;
      int            fill_pct;
      int            prio_top;
      plan_state = empty_queues();
      live_state = empty_queues();
      foreach (queued[i])
         queued[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // schedule with every level empty, ignored fields all ones
      void'(add_word(mk(OP_SCHEDULE, 15, 31)));
      void'(add_word(mk(OP_ENQUEUE, 0, 0)));
      void'(add_word(mk(OP_ENQUEUE, 15, 31)));
      void'(add_word(mk(OP_ENQUEUE, 5, 31)));
      void'(add_word(mk(OP_ENQUEUE, 10, 17)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_SCHEDULE, 9, 21)));
      void'(add_word(mk(OP_SCHEDULE, 6, 10)));
      void'(add_word(mk(OP_SCHEDULE, 15, 31)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      // same task twice on one level: links to itself, pops once
      void'(add_word(mk(OP_ENQUEUE, 3, 2)));
      void'(add_word(mk(OP_ENQUEUE, 3, 2)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      // same task on two levels
      void'(add_word(mk(OP_ENQUEUE, 7, 4)));
      void'(add_word(mk(OP_ENQUEUE, 8, 4)));
      void'(add_word(mk(OP_ENQUEUE, 7, 9)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_ENQUEUE, 9, 0)));
      void'(add_word(mk(OP_ENQUEUE, 1, 0)));
      void'(add_word(mk(OP_ENQUEUE, 2, 0)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));
      void'(add_word(mk(OP_SCHEDULE, 0, 0)));

      fill_pct = 50;
      prio_top = 31;
      for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
         phase = traffic_phase_type'(p);
         n = 0;
         while (n < 180) begin
            // switch at random between filling and draining, narrow levels give long lists
            if (n % 40 == 0) begin
               case ($urandom_range(2))
                  0:       fill_pct = 85;
                  1:       fill_pct = 55;
                  default: fill_pct = 20;
               endcase
               prio_top = ($urandom_range(1) == 0) ? 3 : 31;
            end
            w.id   = ID_W'($urandom_range(15));
            w.prio = PRIO_W'($urandom_range(prio_top));
            if ($urandom_range(99) < fill_pct) begin
               w.op = OP_ENQUEUE;
               if ($urandom_range(99) < 80)
                  for (int k = 0; k < 8 && queued[w.id]; k++)
                     w.id = ID_W'($urandom_range(15));
            end else begin
               w.op   = OP_SCHEDULE;
               w.prio = PRIO_W'($urandom_range(31));
            end
            if (add_word(w))
               n++;
         end
         while (pending_words.size() != 0)
            @(posedge clock);
      end

      while (pending_words.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_picks.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/prqs_pkg.sv
hw/rtl/prqs_ctrl.sv
hw/rtl/prqs_datapath.sv
hw/rtl/priority_ready_queue_scheduler_unit.sv
dv/testbench.sv
